/* sv/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value cache: sequencer states,
// request codes, configuration width and parameter defaults.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Parameter defaults
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Capacity register
    localparam int               CFG_BITS       = 5;
    localparam logic [CFG_BITS-1:0] CAPACITY_RESET = 5'd16;

    // Request codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_STORE  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

/* sv/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// A lookup miss makes a scan sweep; any other request makes a scan sweep and an age
//   update sweep through the single-port-read entry memory, one entry a cycle.
// A new request is taken only once the last result has moved into the output register.
// Reset: aresetn synchronous, active low; empties the cache, capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [KEY_BITS-1:0]           s_key,
    input  logic signed [VALUE_BITS-1:0]  s_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic signed [VALUE_BITS-1:0]  m_read_value,
    output logic                          m_evicted,
    // capacity write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkv_pkg::CFG_BITS-1:0]  cfg_wdata
);

    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
    localparam int REC_W = KEY_BITS + VALUE_BITS + AGE_W;

    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(ENTRIES);
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
    localparam logic [CMP_W-1:0] ONE_C     = CMP_W'(1);

    // Sequencer
    state_t state_reg, state_next;

    // Request
    logic                  func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    // Cache state outside the record memory
    logic [ENTRIES-1:0]    valid_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic [CFG_BITS-1:0]   cap_reg;

    // Sweep counter
    logic [CNT_W-1:0]      idx_reg;

    // Scan results
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic [AGE_W-1:0]      found_age_reg;
    logic [VALUE_BITS-1:0] found_value_reg;
    logic                  vict_any_reg;
    logic [IDX_W-1:0]      vict_idx_reg;
    logic [AGE_W-1:0]      vict_age_reg;
    logic                  free_any_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [IDX_W-1:0]      target_idx_reg;

    // Result held until the output register frees
    logic                  res_hit_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  res_evicted_reg;

    // Output register
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [VALUE_BITS-1:0] m_read_value_reg;
    logic                  m_evicted_reg;

    // Memory port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [REC_W-1:0]      ram_wdata;
    logic [REC_W-1:0]      ram_rdata;

    // Datapath helpers
    logic                  in_beat;
    logic                  cfg_beat;
    logic                  proc_act;
    logic                  sweep_end;
    logic [IDX_W-1:0]      proc_idx;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [AGE_W-1:0]      rd_age;
    logic                  rd_valid;
    logic                  is_insert;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      occ_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  do_evict;
    logic [IDX_W-1:0]      slot_idx;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_value;
    logic [AGE_W-1:0]      wr_age;

    lkv_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (REC_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (proc_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Split the record returned for the entry being processed
    assign in_beat   = s_valid && s_ready;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign proc_act  = (idx_reg != '0);
    assign sweep_end = (idx_reg == LAST_CNT);
    assign proc_idx  = IDX_W'(idx_reg - CNT_W'(1));
    assign ram_raddr = idx_reg[IDX_W-1:0];
    assign rd_key    = ram_rdata[REC_W-1 -: KEY_BITS];
    assign rd_value  = ram_rdata[AGE_W +: VALUE_BITS];
    assign rd_age    = ram_rdata[AGE_W-1:0];
    assign rd_valid  = valid_reg[proc_idx];
    assign is_insert = (func_reg == FUNC_STORE) && !found_reg;

    // Clamp the capacity to 1 .. ENTRIES and test for a full cache
    assign cap_ext = CMP_W'(cap_reg);
    assign occ_ext = CMP_W'(occ_reg);
    always_comb begin
        priority if (cap_ext == '0) begin
            eff_cap = ONE_C;
        end else if (cap_ext > ENTRIES_C) begin
            eff_cap = ENTRIES_C;
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign do_evict = (occ_ext >= eff_cap) && vict_any_reg;

    // Pick the insert slot: the lowest free entry once the victim is dropped
    always_comb begin
        if (do_evict && !(free_any_reg && (free_idx_reg < vict_idx_reg))) begin
            slot_idx = vict_idx_reg;
        end else begin
            slot_idx = free_idx_reg;
        end
    end

    // Build the record written back during the update sweep
    always_comb begin
        wr_key   = rd_key;
        wr_value = rd_value;
        wr_age   = rd_age;
        if (proc_idx == target_idx_reg) begin
            if (is_insert) begin
                wr_key = key_reg;
            end
            if (func_reg == FUNC_STORE) begin
                wr_value = value_reg;
            end
            wr_age = '0;
        end else if (rd_valid && (is_insert || (rd_age < found_age_reg))) begin
            wr_age = rd_age + AGE_W'(1);
        end
    end
    assign ram_wdata = {wr_key, wr_value, wr_age};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sweep_end) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((func_reg == FUNC_LOOKUP) && !found_reg) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (sweep_end) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        ram_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cfg_ready = 1'b1;
            end
            ST_UPDATE: begin
                ram_we = proc_act;
            end
            ST_SCAN, ST_DECIDE, ST_RESULT: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Step the sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) begin
            idx_reg <= sweep_end ? '0 : idx_reg + CNT_W'(1);
        end else begin
            idx_reg <= '0;
        end
    end

    // Capture the request beat
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            func_reg  <= s_func;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    // Track match, victim and first free entry over the scan sweep
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            found_reg    <= 1'b0;
            vict_any_reg <= 1'b0;
            free_any_reg <= 1'b0;
        end else if ((state_reg == ST_SCAN) && proc_act) begin
            if (rd_valid && !found_reg && (rd_key == key_reg)) begin
                found_reg       <= 1'b1;
                found_idx_reg   <= proc_idx;
                found_age_reg   <= rd_age;
                found_value_reg <= rd_value;
            end
            if (rd_valid && (!vict_any_reg || (rd_age > vict_age_reg))) begin
                vict_any_reg <= 1'b1;
                vict_idx_reg <= proc_idx;
                vict_age_reg <= rd_age;
            end
            if (!rd_valid && !free_any_reg) begin
                free_any_reg <= 1'b1;
                free_idx_reg <= proc_idx;
            end
        end
    end

    // Settle the outcome and the target entry
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE) begin
            if (found_reg) begin
                target_idx_reg  <= found_idx_reg;
                res_hit_reg     <= 1'b1;
                res_evicted_reg <= 1'b0;
                res_value_reg   <= (func_reg == FUNC_STORE) ? '0 : found_value_reg;
            end else if (func_reg == FUNC_STORE) begin
                target_idx_reg  <= slot_idx;
                res_hit_reg     <= 1'b0;
                res_evicted_reg <= do_evict;
                res_value_reg   <= '0;
            end else begin
                res_hit_reg     <= 1'b0;
                res_evicted_reg <= 1'b0;
                res_value_reg   <= '1;
            end
        end
    end

    // Hold valid bits, occupancy and capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAPACITY_RESET;
        end else if (cfg_beat) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= cfg_wdata;
        end else if ((state_reg == ST_DECIDE) && is_insert) begin
            // drop the victim, then claim the insert slot
            valid_reg <= (valid_reg & ~(ENTRIES'(do_evict) << vict_idx_reg))
                         | (ENTRIES'(1) << slot_idx);
            if (!do_evict) begin
                occ_reg <= occ_reg + CNT_W'(1);
            end
        end
    end

    // Load the output register, drop it once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_RESULT) && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RESULT) && (!m_valid_reg || m_ready)) begin
            m_hit_reg        <= res_hit_reg;
            m_read_value_reg <= res_value_reg;
            m_evicted_reg    <= res_evicted_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;
    assign m_evicted    = m_evicted_reg;

endmodule

/* sv/lkv_entry_ram.sv */
// ----------------------------------------------------------------------------
// lkv_entry_ram
// Entry record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkv_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 36
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed record
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/lkv_checker.sv */
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker #(
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_hit,
    input logic signed [VALUE_BITS-1:0]  m_read_value,
    input logic                          m_evicted,
    input logic                          cfg_ready
);

    // Drop ready for the request in work
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cfg_ready)
        else $error("ready stayed high after a request beat");

    // Only a store that missed can evict
    a_evict_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> !m_hit && (m_read_value == '0))
        else $error("eviction reported with a hit or a read value");

    // Miss returns all ones on lookup or zero on store
    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_read_value == '0) || (m_read_value == '1))
        else $error("miss with an unexpected read value");

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_hit))
        else $error("stalled result changed");

    // Come out of reset with no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkv_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (.*);
